// File: rtl/window_min_max_mean_tracker_core_macros.svh
// Assertion macros for the window min/max/mean tracker.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef WINDOW_MIN_MAX_MEAN_TRACKER_CORE_MACROS_SVH
`define WINDOW_MIN_MAX_MEAN_TRACKER_CORE_MACROS_SVH

// Overlapping implication, checked outside reset.
`define WMMT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("window tracker assertion failed");

// Non-overlapping implication, checked outside reset.
`define WMMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("window tracker assertion failed");

`endif

// File: rtl/wmmt_pkg.sv
// Shared constants and types of the window min/max/mean tracker.
// No dependencies; imported by every module of the block but wmmt_ram.
package wmmt_pkg;

  localparam int WINDOW   = 128;
  localparam int ADDR_W   = $clog2(WINDOW);
  localparam int SAMPLE_W = 32;
  localparam int WARM_W   = 8;
  localparam int SUM_W    = SAMPLE_W + ADDR_W;
  localparam int CMP_W    = (ADDR_W > WARM_W) ? ADDR_W : WARM_W;

  localparam logic [WARM_W-1:0] WARMUP_RESET = WARM_W'(20);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_FILL = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic              fill;
    logic              push;
    logic              rd_en;
    logic              rd_first;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
  } cmd_t;

endpackage

// File: rtl/wmmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/wmmt_ctrl.sv
// Controller of the window tracker: input/output handshakes and scan sequencing.
// Depends on wmmt_pkg.
module wmmt_ctrl
  import wmmt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  input  logic s_tuser_i,
  output logic s_tready_o,
  input  logic m_tready_i,
  output logic m_tvalid_o,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  logic              accept;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_vld_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q && !m_tready_i;
    cmd_o     = '0;
    cmd_o.rd_addr = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          if (s_tuser_i == OP_FILL) begin
            cmd_o.fill = 1'b1;
            state_d    = ST_DONE;
          end else begin
            cmd_o.push = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (cnt_q == '0);
        cnt_d          = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(WINDOW - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// File: rtl/wmmt_dp.sv
// Datapath of the window tracker: sample ring, warm-up state, min/max/sum accumulators.
// Depends on wmmt_pkg and wmmt_ram.
module wmmt_dp
  import wmmt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  sample_t           sample_i,
  input  logic              cfg_we_i,
  input  logic [WARM_W-1:0] cfg_data_i,
  output sample_t           min_o,
  output sample_t           max_o,
  output sample_t           mean_o
);

  logic [WINDOW-1:0]        valid_q, valid_d;
  sample_t                  fill_q, fill_d;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic                     armed_q, armed_d;
  logic [WARM_W-1:0]        warmup_q;
  logic                     acc_en_q, first_q, vld_rd_q;
  sample_t                  min_q, min_d, max_q, max_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  sample_t                  omin_q, omax_q, omean_q;
  logic                     trigger;
  logic [ADDR_W-1:0]        wr_addr;
  logic [SAMPLE_W-1:0]      ram_rdata;
  sample_t                  elem;
  logic signed [SUM_W-1:0]  sample_ext, elem_ext;
  logic [SUM_W-1:0]         sum_adj;

  wmmt_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(wr_addr),
    .wdata_i(sample_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(ram_rdata)
  );

  assign trigger = armed_q && (warmup_q != '0) && (CMP_W'(pos_q) > CMP_W'(warmup_q));
  assign wr_addr = trigger ? '0 : pos_q;
  assign elem       = vld_rd_q ? sample_t'(ram_rdata) : fill_q;
  assign sample_ext = SUM_W'(sample_i);
  assign elem_ext   = SUM_W'(elem);
  assign sum_adj    = sum_q + (sum_q[SUM_W-1] ? SUM_W'(WINDOW - 1) : SUM_W'(0));

  always_comb begin
    valid_d = valid_q;
    fill_d  = fill_q;
    pos_d   = pos_q;
    armed_d = armed_q;
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    if (cmd_i.fill) begin
      valid_d = '0;
      fill_d  = sample_i;
      pos_d   = '0;
      armed_d = 1'b1;
      min_d   = sample_i;
      max_d   = sample_i;
      sum_d   = sample_ext <<< ADDR_W;
    end else if (cmd_i.push) begin
      if (trigger) begin
        valid_d = '0;
        fill_d  = sample_i;
        armed_d = 1'b0;
      end
      valid_d[wr_addr] = 1'b1;
      pos_d            = wr_addr + ADDR_W'(1);
    end
    if (acc_en_q) begin
      if (first_q) begin
        min_d = elem;
        max_d = elem;
        sum_d = elem_ext;
      end else begin
        if (elem < min_q) begin
          min_d = elem;
        end
        if (elem > max_q) begin
          max_d = elem;
        end
        sum_d = sum_q + elem_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      fill_q   <= '0;
      pos_q    <= '0;
      armed_q  <= 1'b1;
      warmup_q <= WARMUP_RESET;
      acc_en_q <= 1'b0;
      first_q  <= 1'b0;
      vld_rd_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      armed_q  <= armed_d;
      if (cfg_we_i) begin
        warmup_q <= cfg_data_i;
      end
      acc_en_q <= cmd_i.rd_en;
      first_q  <= cmd_i.rd_first;
      vld_rd_q <= valid_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
    sum_q <= sum_d;
    if (cmd_i.out_load) begin
      omin_q  <= min_q;
      omax_q  <= max_q;
      omean_q <= sample_t'(sum_adj[ADDR_W +: SAMPLE_W]);
    end
  end

  assign min_o  = omin_q;
  assign max_o  = omax_q;
  assign mean_o = omean_q;

endmodule

// File: rtl/window_min_max_mean_tracker_core.sv
// Top level of the window min/max/mean tracker.
// Depends on wmmt_pkg, wmmt_ctrl, wmmt_dp and the assertion macro header.
//
// Usage:
//   Input stream s_axis: tdata carries the Q16.16 sample, tuser the operation
//   (0 push a sample, 1 fill the whole window). Output stream m_axis: tdata
//   carries min, max and mean of the window, each Q16.16.
//   Config channel cfg_*: one 8-bit warm-up count, always ready; write it
//   only while the block is idle.
//   A push writes the sample into a 128-entry ring RAM, then scans the ring
//   one entry per cycle through its single read port; the result passes the
//   scan states, a drain state and the done state into the output register. A
//   fill result goes from the done state into the output register. One item
//   is in flight at a time, so no new sample is taken before the previous
//   result is loaded; for a push the ring scan sets the pace.
//   Reset clears the ring to zero (per-entry valid bits, no clearing pass),
//   rewinds the write position, arms warm-up and sets the warm-up count to 20.
//   A stalled receiver holds the result in the output register; a finished
//   scan waits for the register to drain and no new transaction is taken
//   until its result is loaded.
`include "window_min_max_mean_tracker_core_macros.svh"

module window_min_max_mean_tracker_core
  import wmmt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
  input  logic                  s_axis_tuser,   // [0] op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [3*SAMPLE_W-1:0] m_axis_tdata,   // [31:0] min, [63:32] max, [95:64] mean
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [WARM_W-1:0]     cfg_data_i
);

  cmd_t    cmd;
  sample_t win_min, win_max, win_mean;

  assign cfg_ready_o = 1'b1;

  wmmt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tuser_i (s_axis_tuser),
    .s_tready_o(s_axis_tready),
    .m_tready_i(m_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .cmd_o     (cmd)
  );

  wmmt_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sample_i  (sample_t'(s_axis_tdata)),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .min_o     (win_min),
    .max_o     (win_max),
    .mean_o    (win_mean)
  );

  assign m_axis_tdata = {win_mean, win_max, win_min};

  `WMMT_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `WMMT_ASSERT_IMPL(a_no_accept_in_scan, cmd.rd_en, !s_axis_tready)
  `WMMT_ASSERT_IMPL(a_result_frees_input, $rose(m_axis_tvalid), s_axis_tready)
  `WMMT_ASSERT_IMPL(a_fill_echo,
      s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_FILL) && !m_axis_tvalid,
      ##2 (m_axis_tvalid && (m_axis_tdata[SAMPLE_W-1:0] == $past(s_axis_tdata, 2))))

endmodule

// File: tb/window_stats_checker.sv
// Scoreboard for the window min/max/mean tracker: follows the sample, result and
// warm-up channels, keeps its own copy of the ring and checks every result.
// Depends on wmmt_pkg for widths, op codes and the warm-up reset value.
module window_stats_checker
  import wmmt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [SAMPLE_W-1:0]   in_data_i,
  input  logic                  in_op_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [3*SAMPLE_W-1:0] out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [WARM_W-1:0]     cfg_data_i,
  output int                    outstanding_o,
  output int                    fail_count_o,
  output int                    refill_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sample_t mean;
    sample_t hi;
    sample_t lo;
  } stats_t;

  sample_t           ring [WINDOW];
  logic [ADDR_W-1:0] wr_pos;
  logic              armed;
  logic [WARM_W-1:0] warmup;
  stats_t            expected_stats_q [$];
  stats_t            want_stats;
  stats_t            got_stats;
  int                err_total    = 0;
  int                refill_total = 0;

  assign fail_count_o   = err_total;
  assign refill_count_o = refill_total;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $realtime, what);
    err_total++;
  endtask

  task automatic check_field(input string name, input sample_t got, input sample_t want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0d (0x%08h), want %0d (0x%08h)",
                                name, got, got, want, want));
    end
  endtask

  function automatic void load_ring(input sample_t val);
    for (int i = 0; i < WINDOW; i++) begin
      ring[i] = val;
    end
    wr_pos = '0;
  endfunction

  function automatic stats_t predict_window_stats(input logic op, input sample_t val);
    stats_t                  res;
    sample_t                 lo;
    sample_t                 hi;
    logic signed [SUM_W-1:0] total;
    if (op == OP_FILL) begin
      load_ring(val);
      armed    = 1'b1;
      res.lo   = val;
      res.hi   = val;
      res.mean = val;
      return res;
    end
    if (armed && warmup != '0 && wr_pos > warmup) begin
      load_ring(val);
      armed = 1'b0;
      refill_total++;
    end
    ring[wr_pos] = val;
    wr_pos       = wr_pos + 1'b1;
    lo    = ring[0];
    hi    = ring[0];
    total = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (ring[i] < lo) lo = ring[i];
      if (ring[i] > hi) hi = ring[i];
      total += ring[i];
    end
    res.lo   = lo;
    res.hi   = hi;
    res.mean = sample_t'(total / WINDOW);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_ring('0);
      armed  = 1'b1;
      warmup = WARMUP_RESET;
      expected_stats_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) warmup = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_stats_q.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want_stats = expected_stats_q.pop_front();
          got_stats  = stats_t'(out_data_i);
          check_field("window_min", got_stats.lo, want_stats.lo);
          check_field("window_max", got_stats.hi, want_stats.hi);
          check_field("window_mean", got_stats.mean, want_stats.mean);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_stats_q.push_back(predict_window_stats(in_op_i, in_data_i));
      end
      outstanding_o <= expected_stats_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the window min/max/mean tracker testbench: clock, reset, sample and
// warm-up stimulus with random stalls, and the verdict.
// Depends on wmmt_pkg, window_min_max_mean_tracker_core and window_stats_checker.
module tb_top
  import wmmt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam sample_t Q_MAX = 32'sh7FFF_FFFF;
  localparam sample_t Q_MIN = 32'sh8000_0000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tuser  = OP_PUSH;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [3*SAMPLE_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [WARM_W-1:0]     cfg_data_i    = '0;

  int outstanding;
  int fail_count;
  int refill_count;
  int item_total = 0;
  int fill_total = 0;
  bit no_idle    = 1'b0;

  logic [WARM_W-1:0] warm_settings [7] = '{8'd20, 8'd0, 8'd1, 8'd126, 8'd127, 8'd255, 8'd0};

  window_min_max_mean_tracker_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  window_stats_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_i     (s_axis_tready),
    .in_data_i      (s_axis_tdata),
    .in_op_i        (s_axis_tuser),
    .out_valid_i    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_i     (m_axis_tdata),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .outstanding_o  (outstanding),
    .fail_count_o   (fail_count),
    .refill_count_o (refill_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 22);
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3:    return sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic drive_item(input logic op, input sample_t val);
    if (!no_idle && $urandom_range(0, 99) < 22) begin
      repeat ($urandom_range(1, 160)) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    item_total++;
    if (op == OP_FILL) fill_total++;
  endtask

  task automatic await_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_warmup(input logic [WARM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int run_len;
    int phase_count;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // negative sum truncates toward zero, then extremes with the reset warm-up count
    drive_item(OP_PUSH, -32'sd1);
    drive_item(OP_PUSH, Q_MAX);
    drive_item(OP_PUSH, Q_MIN);
    drive_item(OP_FILL, Q_MAX);
    drive_item(OP_PUSH, Q_MIN);
    drive_item(OP_FILL, Q_MIN);
    drive_item(OP_PUSH, Q_MAX);
    drive_item(OP_FILL, '0);

    // refill on the fourth push, then again after a fill re-arms
    await_drained();
    write_warmup(8'd2);
    for (int i = 1; i <= 5; i++) drive_item(OP_PUSH, sample_t'(i * 65536));
    drive_item(OP_FILL, -32'sd5);
    for (int i = 7; i <= 10; i++) drive_item(OP_PUSH, sample_t'(-i));

    // zero count keeps warm-up off
    await_drained();
    write_warmup(8'd0);
    drive_item(OP_FILL, 32'sd3);
    for (int i = 0; i < 4; i++) drive_item(OP_PUSH, pick_sample());

    for (int p = 0; p < 7; p++) begin
      await_drained();
      write_warmup((p == 6) ? WARM_W'($urandom_range(2, 125)) : warm_settings[p]);
      no_idle     = (p == 3);
      phase_count = 0;
      while (phase_count < 160) begin
        if ($urandom_range(0, 9) != 0) begin
          drive_item(OP_FILL, pick_sample());
          phase_count++;
        end
        run_len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40) : $urandom_range(41, 200);
        repeat (run_len) drive_item(OP_PUSH, pick_sample());
        phase_count += run_len;
      end
    end
    no_idle = 1'b0;

    await_drained();
    repeat (140) @(posedge clk_i);
    $display("Drove %0d transactions (%0d window fills), %0d warm-up refills predicted",
             item_total, fill_total, refill_count);
    $display("Warm-up counts 20, 2, 0, 1, 126, 127, 255 and one random; both streams stalled");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/wmmt_pkg.sv
rtl/wmmt_ram.sv
rtl/wmmt_ctrl.sv
rtl/wmmt_dp.sv
rtl/window_min_max_mean_tracker_core.sv
tb/window_stats_checker.sv
tb/tb_top.sv
